FILE: sv/stg_pkg.sv
// ----------------------------------------------------------------------------
// stg_pkg: shared types and constants of the sine tone generator
// Holds the field widths, the register indexes, the controller/datapath
// command and status bundles, and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package stg_pkg;

    localparam int TABLE_ADDR_BITS = 8;
    localparam int SAMPLE_BITS     = 16;

    localparam int PERIOD_W  = 16;
    localparam int VOLUME_W  = 15;
    localparam int PHASE_W   = 16;
    localparam int OUT_W     = 16;
    localparam int TAB_VAL_W = 15;
    localparam int TAB_N     = 1 << TABLE_ADDR_BITS;
    localparam int TAB_AW    = TABLE_ADDR_BITS + 1;
    localparam int STEP_W    = $clog2(PHASE_W);
    localparam int PROD_W    = TAB_VAL_W + VOLUME_W;
    localparam int SAT_W     = ((SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W) + 1;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME = CFG_INDEX_W'(1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(187);
    localparam logic [VOLUME_W-1:0] VOLUME_RESET = VOLUME_W'(3000);

    localparam logic signed [SAT_W-1:0] SAMPLE_HI = SAT_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAMPLE_LO = SAT_W'(-(1 << (SAMPLE_BITS - 1)));

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q15_MAX     = 64'd32767;

    typedef struct packed {
        logic start;     // tick accepted: pick the count, advance the counter
        logic div_step;  // one restoring division step
        logic look;      // table lookup with quadrant folding
        logic mul;       // volume scaling and saturation
        logic load_out;  // move the finished sample into the output register
    } stg_cmd_t;

    typedef struct packed {
        logic period_small;  // period below two: the frame is zero
        logic out_stall;     // output register full and not being taken
    } stg_status_t;

    typedef logic [TAB_VAL_W-1:0] sine_tab_t [0:TAB_N];

    // Shift-and-subtract long division, used only while the table is built.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int              b;
        quo = 64'd0;
        rem = 64'd0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series of sin in unsigned Q2.30, rounded to Q1.15.
    function automatic logic [TAB_VAL_W-1:0] sine_q15(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        longint unsigned dv;
        int              n;
        x    = (HALF_PI_Q30 * longint'(k)) >> TABLE_ADDR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (n = 1; n <= 8; n++) begin
            dv   = longint'((2 * n) * (2 * n + 1));
            term = div_u64((term * x2) >> 30, dv);
            if ((n % 2) == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum + (64'd1 << 14)) >> 15;
        if (r > Q15_MAX) begin
            r = Q15_MAX;
        end
        return r[TAB_VAL_W-1:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t t;
        int        k;
        for (k = 0; k <= TAB_N; k++) begin
            t[k] = sine_q15(k);
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: sv/sine_tone_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_generator: direct digital synthesis test-tone oscillator
// Each tick transaction yields one stereo frame of a sine tone whose period
// and peak amplitude are set through the configuration channel.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tdata bit 0 is the tick. A transaction with tick set
// produces one frame on m_* and advances the sample counter; a transaction
// with tick clear produces nothing and changes no state.
// Output channel m_*: m_tdata carries the left sample in bits 15:0 and the
// right sample, equal to it, in bits 31:16, both signed.
// Configuration channel cfg_*: index 0 writes the period in samples, index 1
// the volume; other indexes are ignored. cfg_ready is always high. Write only
// while no tick is in flight.
// Sequence: an accepted tick runs the bit-serial phase divider, the table
// lookup and the scaling, then the sample is loaded into the output register
// once it is free and m_tvalid rises; with a period below two the sample is
// zero and goes straight to the output register. A new tick is taken only
// after the previous sample has moved into the output register.
// Reset: the period returns to 187, the volume to 3000, the counter to zero.
// When the receiver stalls, the finished frame waits in the output register
// while the next tick is accepted and computed; that one then waits in turn.
// ----------------------------------------------------------------------------
module sine_tone_generator
    import stg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,    // [0] tick, [7:1] zero
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [2*OUT_W-1:0]      m_tdata,    // [15:0] left_sample, [31:16] right_sample
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    stg_cmd_t          cmd;
    stg_status_t       status;
    logic [OUT_W-1:0]  sample;

    assign cfg_ready = 1'b1;

    stg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .tick     (s_tdata[0]),
        .status   (status),
        .cmd      (cmd)
    );

    stg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .sample    (sample)
    );

    assign m_tdata = {sample, sample};

endmodule

FILE: sv/stg_ctrl.sv
// ----------------------------------------------------------------------------
// stg_ctrl: sequencing state machine of the sine tone generator
// Accepts input transactions, runs the division steps, the lookup and the
// scaling, and hands the sample to the output register when it is free.
// ----------------------------------------------------------------------------
module stg_ctrl
    import stg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        tick,
    input  stg_status_t status,
    output stg_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOOK,
        ST_MUL,
        ST_FIN
    } state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PHASE_W - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_cnt_reg;
    logic [STEP_W-1:0]   step_cnt_next;
    logic                s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && tick) begin
                    cmd.start = 1'b1;
                    if (status.period_small) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next    = ST_DIV;
                        step_cnt_next = '0;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == LAST_STEP) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!status.out_stall) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // The full set of division steps is always run before the lookup.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_cnt_reg == LAST_STEP) |=> (state_reg == ST_LOOK))
        else $error("division left early or late");

    // A tick with a usable period starts the divider from its first step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && tick && !status.period_small) |=>
            (state_reg == ST_DIV && step_cnt_reg == '0))
        else $error("divider not started after tick");

endmodule

FILE: sv/stg_datapath.sv
// ----------------------------------------------------------------------------
// stg_datapath: registers and arithmetic of the sine tone generator
// Holds the configuration, the sample counter, a bit-serial restoring
// divider for the phase, the table lookup, the scaling and the output register.
// ----------------------------------------------------------------------------
module stg_datapath
    import stg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  stg_cmd_t                cmd,
    output stg_status_t             status,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_W-1:0]        sample
);

    logic [PERIOD_W-1:0]   period_reg;
    logic [VOLUME_W-1:0]   volume_reg;
    logic [PHASE_W-1:0]    phase_count_reg;
    logic [PHASE_W-1:0]    phase_count_next;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [PERIOD_W-1:0]   rem_next;
    logic [PHASE_W-1:0]    quot_reg;
    logic [PHASE_W-1:0]    quot_next;
    logic [TAB_VAL_W-1:0]  tab_val_reg;
    logic                  neg_reg;
    logic [OUT_W-1:0]      sample_reg;
    logic [OUT_W-1:0]      sample_next;
    logic [OUT_W-1:0]      out_reg;
    logic                  m_tvalid_reg;

    logic [PHASE_W-1:0]          count;
    logic [PHASE_W-1:0]          count_inc;
    logic [PERIOD_W:0]           rem_shift;
    logic                        qbit;
    logic [TABLE_ADDR_BITS-1:0]  idx;
    logic [TAB_AW-1:0]           tab_addr;
    logic [PROD_W-1:0]           product;
    logic [TAB_VAL_W-1:0]        mag;
    logic signed [SAT_W-1:0]     val;
    logic signed [SAT_W-1:0]     val_sat;

    assign status.period_small = (period_reg < PERIOD_W'(2));
    assign status.out_stall    = m_tvalid_reg && !m_tready;

    // A counter left beyond a lowered period restarts from zero.
    assign count     = (phase_count_reg < period_reg) ? phase_count_reg : '0;
    assign count_inc = count + 1'b1;

    always_comb begin
        phase_count_next = phase_count_reg;
        if (cmd.start) begin
            if (status.period_small) begin
                phase_count_next = '0;
            end else begin
                phase_count_next = (count_inc >= period_reg) ? '0 : count_inc;
            end
        end
    end

    // Restoring division of (count << 16) by the period, one quotient bit a step.
    assign rem_shift = {rem_reg, 1'b0};
    assign qbit      = (rem_shift >= {1'b0, period_reg});

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (cmd.start) begin
            rem_next = count;
        end else if (cmd.div_step) begin
            rem_next  = qbit ? PERIOD_W'(rem_shift - {1'b0, period_reg})
                             : rem_shift[PERIOD_W-1:0];
            quot_next = {quot_reg[PHASE_W-2:0], qbit};
        end
    end

    // Odd quadrants read the table mirrored.
    assign idx      = quot_reg[PHASE_W-3 -: TABLE_ADDR_BITS];
    assign tab_addr = quot_reg[PHASE_W-2] ? TAB_AW'(TAB_N) - {1'b0, idx} : {1'b0, idx};

    assign product = tab_val_reg * volume_reg;
    assign mag     = product[PROD_W-1 -: TAB_VAL_W];
    assign val     = neg_reg ? -$signed({{(SAT_W - TAB_VAL_W){1'b0}}, mag})
                             : $signed({{(SAT_W - TAB_VAL_W){1'b0}}, mag});

    always_comb begin
        val_sat = val;
        if (val > SAMPLE_HI) begin
            val_sat = SAMPLE_HI;
        end else if (val < SAMPLE_LO) begin
            val_sat = SAMPLE_LO;
        end
    end

    always_comb begin
        sample_next = sample_reg;
        if (cmd.start) begin
            sample_next = '0;
        end else if (cmd.mul) begin
            sample_next = val_sat[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= PERIOD_RESET;
            volume_reg      <= VOLUME_RESET;
            phase_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_write && cfg_index == REG_PERIOD) begin
                period_reg <= cfg_data[PERIOD_W-1:0];
            end
            if (cfg_write && cfg_index == REG_VOLUME) begin
                volume_reg <= cfg_data[VOLUME_W-1:0];
            end
            phase_count_reg <= phase_count_next;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        sample_reg <= sample_next;
        if (cmd.look) begin
            tab_val_reg <= SINE_TAB[tab_addr];
            neg_reg     <= quot_reg[PHASE_W-1];
        end
        if (cmd.load_out) begin
            out_reg <= sample_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign sample   = out_reg;

    // The partial remainder stays below the divisor throughout the division.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < period_reg))
        else $error("division remainder out of range");

    // After a tick the counter lies inside the period.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (phase_count_reg < period_reg || period_reg < PERIOD_W'(2)))
        else $error("sample counter beyond period");

    // A pending result is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(m_tvalid_reg && !m_tready))
        else $error("output result overwritten");

endmodule

FILE: sim/tb_sine_tone_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_tone_generator: self-checking bench for the sine tone generator
// Tick transactions are fed in bursts while the receiver stalls on its own
// pattern. Every frame is compared against a sample predicted in the bench
// from its own quarter-wave table, counter and register copies. Directed
// cases come first, then randomized register settings with random ticks.
// ----------------------------------------------------------------------------
module tb_sine_tone_generator;
    import stg_pkg::*;

    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int              DRAIN_CYCLES     = 40;
    localparam int              RANDOM_TICKS     = 300;
    localparam int              MAX_PRINTED      = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = CFG_INDEX_W'(255);

    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'd0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [2*OUT_W-1:0]     m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor state.
    logic [TAB_VAL_W-1:0] sine_lut [0:TAB_N];
    logic [PERIOD_W-1:0]  tone_period;
    logic [VOLUME_W-1:0]  pred_volume;
    logic [PHASE_W-1:0]   tone_count;

    logic      tick_queue [$];
    logic [OUT_W-1:0] sample_expect_q [$];

    logic      tick_taken = 1'b0;
    logic      cfg_taken  = 1'b0;
    int        gap_left   = 0;
    int        burst_left = 0;
    rx_mode_t  rx_mode    = RX_OPEN;
    int        rx_left    = 0;
    int        rx_cycle   = 0;

    int mismatch_count = 0;
    int frames_checked = 0;
    int ticks_sent     = 0;
    int idles_sent     = 0;
    int reg_writes     = 0;

    sine_tone_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Taylor series of sin(pi/2 * k / N) in unsigned Q2.30, rounded to Q1.15.
    function automatic logic [TAB_VAL_W-1:0] taylor_sine_q15(input int unsigned k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned rounded;
        int unsigned     n;
        ang    = (QUARTER_TURN_Q30 * longint'(k)) >> TABLE_ADDR_BITS;
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = ang;
        for (n = 1; n <= 8; n++) begin
            term = ((term * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        rounded = (acc + (64'd1 << 14)) >> 15;
        if (rounded > 64'd32767) begin
            rounded = 64'd32767;
        end
        return rounded[TAB_VAL_W-1:0];
    endfunction

    function automatic void reset_tone_state();
        tone_period = PERIOD_RESET;
        pred_volume = VOLUME_RESET;
        tone_count  = '0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PERIOD: tone_period = data[PERIOD_W-1:0];
            REG_VOLUME: pred_volume = data[VOLUME_W-1:0];
            default: ;
        endcase
    endfunction

    // Computes the frame for one tick and advances the sample counter.
    function automatic logic [OUT_W-1:0] next_tone_sample();
        logic [PHASE_W-1:0]   count;
        logic [31:0]          turn;
        int                   idx;
        logic [TAB_VAL_W-1:0] tab_mag;
        logic [PROD_W-1:0]    prod;
        logic [OUT_W-1:0]     mag;
        if (tone_period < 2) begin
            tone_count = '0;
            return '0;
        end
        // A counter left beyond a lowered period restarts from zero.
        count = (tone_count < tone_period) ? tone_count : '0;
        turn  = {count, 16'd0} / {16'd0, tone_period};
        idx   = int'(turn[13 -: TABLE_ADDR_BITS]);
        tab_mag = turn[14] ? sine_lut[TAB_N - idx] : sine_lut[idx];
        prod  = PROD_W'(tab_mag) * PROD_W'(pred_volume);
        // The product never exceeds the 16-bit range, so no clipping is needed.
        mag   = OUT_W'(prod >> 15);
        count = count + 1'b1;
        tone_count = (count >= tone_period) ? '0 : count;
        return turn[15] ? OUT_W'(0) - mag : mag;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("mismatch at %0t ns: %s", $realtime, msg);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_ticks(input int count, input logic tick);
        repeat (count) tick_queue.push_back(tick);
    endtask

    // Waits until every queued transaction went out and every frame came back,
    // then lets the block settle from any tick that yields no frame.
    task automatic wait_idle();
        do @(posedge aclk);
        while (tick_queue.size() != 0 || s_tvalid || sample_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge aclk) begin : drive_ticks
        logic next_valid;
        logic next_tick;
        next_valid = s_tvalid;
        next_tick  = s_tdata[0];
        if (!aresetn) begin
            next_valid = 1'b0;
        end else if (!s_tvalid || tick_taken) begin
            next_valid = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (tick_queue.size() != 0) begin
                next_valid = 1'b1;
                next_tick  = tick_queue.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
                end else begin
                    burst_left--;
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= {7'd0, next_tick};
    end

    // Receiver: switches between stall patterns, each held for a random stretch.
    always @(negedge aclk) begin : drive_ready
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
        end else begin
            rx_left--;
        end
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
            RX_PERIODIC: m_tready <= ((rx_cycle % 37) < 21);
            default:     m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin : watch_ports
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            tick_taken <= 1'b0;
            cfg_taken  <= 1'b0;
            reset_tone_state();
        end else begin
            tick_taken <= s_tvalid && s_tready;
            cfg_taken  <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                apply_reg_write(cfg_index, cfg_data);
                reg_writes++;
            end
            // Check the outgoing frame before queueing a new expectation.
            if (m_tvalid && m_tready) begin
                if (sample_expect_q.size() == 0) begin
                    report_mismatch($sformatf("frame 0x%08h with no tick outstanding", m_tdata));
                end else begin
                    want = sample_expect_q.pop_front();
                    frames_checked++;
                    if (m_tdata[15:0] !== want) begin
                        report_mismatch($sformatf("left sample %0d, expected %0d",
                                                  $signed(m_tdata[15:0]), $signed(want)));
                    end
                    if (m_tdata[31:16] !== want) begin
                        report_mismatch($sformatf("right sample %0d, expected %0d",
                                                  $signed(m_tdata[31:16]), $signed(want)));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tdata[0]) begin
                    sample_expect_q.push_back(next_tone_sample());
                    ticks_sent++;
                end else begin
                    idles_sent++;
                end
            end
        end
    end

    initial begin : run_stimulus
        int k;
        int n_items;
        int random_ticks;
        logic tick;
        logic [CFG_DATA_W-1:0] pick_period;
        logic [CFG_DATA_W-1:0] pick_volume;

        for (k = 0; k <= TAB_N; k++) begin
            sine_lut[k] = taylor_sine_q15(k);
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values, with an idle tick in the middle.
        queue_ticks(2, 1'b1);
        queue_ticks(1, 1'b0);
        queue_ticks(2, 1'b1);
        wait_idle();

        // Period of four lands exactly on the quadrant edges; volume data with
        // bit 15 set must keep only the low 15 bits.
        write_reg(REG_PERIOD, 16'd4);
        write_reg(REG_VOLUME, 16'hFFFF);
        queue_ticks(5, 1'b1);
        wait_idle();

        // Writes to indexes without a register are ignored.
        write_reg(REG_UNUSED_LO, 16'd3);
        write_reg(REG_UNUSED_HI, 16'hFFFF);
        queue_ticks(2, 1'b1);
        wait_idle();

        // Periods of zero and one give silent frames and clear the counter.
        write_reg(REG_PERIOD, 16'd0);
        queue_ticks(2, 1'b1);
        wait_idle();
        write_reg(REG_PERIOD, 16'd1);
        queue_ticks(1, 1'b1);
        wait_idle();

        write_reg(REG_PERIOD, 16'hFFFF);
        write_reg(REG_VOLUME, 16'd0);
        queue_ticks(2, 1'b1);
        wait_idle();

        // Lowering the period below the running count restarts the tone.
        write_reg(REG_PERIOD, 16'd40);
        write_reg(REG_VOLUME, 16'd12345);
        queue_ticks(6, 1'b1);
        wait_idle();
        write_reg(REG_PERIOD, 16'd5);
        queue_ticks(3, 1'b1);
        wait_idle();

        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 4))
                        0: pick_period = 16'd0;
                        1: pick_period = 16'd1;
                        2: pick_period = 16'd2;
                        3: pick_period = 16'd3;
                        default: pick_period = 16'hFFFF;
                    endcase
                end
                1: pick_period = 16'($urandom_range(0, 65535));
                default: pick_period = 16'($urandom_range(2, 300));
            endcase
            case ($urandom_range(0, 7))
                0: pick_volume = 16'd0;
                1: pick_volume = 16'h7FFF;
                2: pick_volume = 16'hFFFF;
                default: pick_volume = 16'($urandom_range(0, 65535));
            endcase
            // Skipping a write now and then keeps the old counter running into
            // a changed period.
            if ($urandom_range(0, 4) != 0) begin
                write_reg(REG_PERIOD, pick_period);
            end
            if ($urandom_range(0, 4) != 0) begin
                write_reg(REG_VOLUME, pick_volume);
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_INDEX_W'($urandom_range(2, 255)), 16'($urandom_range(0, 65535)));
            end
            n_items = $urandom_range(8, 50);
            repeat (n_items) begin
                tick = ($urandom_range(0, 4) != 0);
                tick_queue.push_back(tick);
                if (tick) begin
                    random_ticks++;
                end
            end
            wait_idle();
        end

        if (sample_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d frames never arrived", sample_expect_q.size()));
        end
        $display("Covered %0d tick frames (%0d checked) and %0d idle transactions,",
                 ticks_sent, frames_checked, idles_sent);
        $display("with %0d register writes across tiny, small and full periods and volumes.",
                 reg_writes);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
